// File: hdl/aba_pkg.sv
// ----------------------------------------------------------------------------
// aba_pkg: shared types and constants
// Sizes, request and status codes for the arena block allocator.
// ----------------------------------------------------------------------------
package aba_pkg;
  localparam int MAX_BLOCKS = 64;
  localparam int SLOT_BITS = $clog2(MAX_BLOCKS);
  localparam int LINK_BITS = SLOT_BITS + 1;
  localparam int OFFSET_BITS = 20;
  localparam int PAGE_HEADER_BYTES = 48;
  localparam int BLOCK_HEADER_BYTES = 48;
  localparam int TAG_BITS = 32;
  localparam int SUM_BITS = OFFSET_BITS + 2;

  localparam logic [LINK_BITS-1:0] NONE_SLOT = LINK_BITS'(MAX_BLOCKS);
  localparam logic [SUM_BITS-1:0] PAGE_HDR = SUM_BITS'(PAGE_HEADER_BYTES);
  localparam logic [SUM_BITS-1:0] BLOCK_HDR = SUM_BITS'(BLOCK_HEADER_BYTES);

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_FREE = 3'd1;
  localparam logic [2:0] REQ_NEXT = 3'd2;
  localparam logic [2:0] REQ_PREV = 3'd3;
  localparam logic [2:0] REQ_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;
  localparam logic [1:0] ST_END = 2'd3;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] size;
    logic [TAG_BITS-1:0] tag;
    logic [LINK_BITS-1:0] next;
    logic [LINK_BITS-1:0] prev;
  } slot_t;
endpackage

// File: hdl/aba_table.sv
// ----------------------------------------------------------------------------
// aba_table: slot memory
// One write port, one registered read port over the slot records.
// ----------------------------------------------------------------------------
module aba_table import aba_pkg::*; (
  input  logic                 clk,
  input  logic                 we,
  input  logic [SLOT_BITS-1:0] waddr,
  input  slot_t                wdata,
  input  logic [SLOT_BITS-1:0] raddr,
  output slot_t                rdata
);
  slot_t mem [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/arena_block_allocator.sv
// ----------------------------------------------------------------------------
// arena_block_allocator: first-fit arena allocator
// Address-ordered linked slot table, walked one slot per step by a sequencer.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// req     | in        | req_valid / req_stall
// rsp     | out       | rsp_valid / rsp_stall
// cfg     | in        | cfg_valid / cfg_ready
// An allocation checks the last block first, then walks from the head, reading
// each block and its successor (slot memory read port, one access in flight);
// free, and a walk from a given offset, search the slots by index. Clear and a
// config transfer are taken from idle. Reset is synchronous; the valid bits
// clear at once. The result register holds while rsp_stall is high and a new
// request waits until it has been taken.
module arena_block_allocator import aba_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  logic [2:0]             req_type,
  input  logic [OFFSET_BITS-1:0] block_offset,
  input  logic [OFFSET_BITS-1:0] request_bytes,
  input  logic [TAG_BITS-1:0]    owner_tag,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output logic [1:0]             status,
  output logic [OFFSET_BITS-1:0] result_offset,
  output logic [OFFSET_BITS-1:0] result_bytes,
  output logic [TAG_BITS-1:0]    result_tag,
  output logic [6:0]             live_blocks,
  output logic [OFFSET_BITS-1:0] used_bytes,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [OFFSET_BITS-1:0] cfg_data
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIND = 4'd1;  // search by offset: issue read
  localparam logic [3:0] S_FCHK = 4'd2;  // compare
  localparam logic [3:0] S_FREE = 4'd3;  // unlink: patch prev
  localparam logic [3:0] S_FRN = 4'd4;   // unlink: patch next
  localparam logic [3:0] S_ARD = 4'd5;   // alloc: read t
  localparam logic [3:0] S_ACHK = 4'd6;  // alloc: check t
  localparam logic [3:0] S_ANRD = 4'd7;  // alloc: read next of t
  localparam logic [3:0] S_ANCK = 4'd8;  // alloc: gap check
  localparam logic [3:0] S_PLACE = 4'd9; // write new slot
  localparam logic [3:0] S_LINKP = 4'd10;
  localparam logic [3:0] S_LINKN = 4'd11;
  localparam logic [3:0] S_WALK = 4'd12;
  localparam logic [3:0] S_WCHK = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  logic [3:0] state;
  logic [OFFSET_BITS-1:0] arena;
  logic [MAX_BLOCKS-1:0] valid;
  logic [LINK_BITS-1:0] head, tail;
  logic [6:0] total;
  logic [OFFSET_BITS-1:0] used;
  logic [2:0] rtype;
  logic [OFFSET_BITS-1:0] roff, rsize;
  logic [TAG_BITS-1:0] rtag;
  logic [SLOT_BITS:0] idx;      // search index
  logic [LINK_BITS-1:0] cur, fs, np, nn, ret;
  logic [6:0] steps;
  slot_t tcur;
  logic [SUM_BITS-1:0] new_start;
  logic [1:0] rstat;

  logic we;
  logic [SLOT_BITS-1:0] waddr, raddr;
  slot_t wdata, rdata;
  logic out_load;

  aba_table u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // first free slot (priority encoder over valid bits)
  logic [LINK_BITS-1:0] free_idx;
  always_comb begin
    free_idx = NONE_SLOT;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid[i]) free_idx = LINK_BITS'(i);
    end
  end

  logic [SUM_BITS-1:0] need, t_end, t_start;
  assign need = BLOCK_HDR + SUM_BITS'(rsize);
  assign t_start = SUM_BITS'(rdata.start);
  assign t_end = t_start + BLOCK_HDR + SUM_BITS'(rdata.size);

  assign req_stall = (state != S_IDLE) || rsp_valid || cfg_valid;
  assign cfg_ready = (state == S_IDLE) && !rsp_valid;

  // memory port control
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = cur[SLOT_BITS-1:0];
    unique case (state)
      S_FIND: raddr = idx[SLOT_BITS-1:0];
      S_FCHK: raddr = rdata.prev[SLOT_BITS-1:0];
      S_ANRD: raddr = rdata.next[SLOT_BITS-1:0];
      S_PLACE: begin
        we = 1'b1;
        waddr = fs[SLOT_BITS-1:0];
        wdata.start = new_start[OFFSET_BITS-1:0];
        wdata.size = rsize;
        wdata.tag = rtag;
        wdata.prev = np;
        wdata.next = nn;
        raddr = np[SLOT_BITS-1:0];
      end
      S_LINKP: begin
        raddr = nn[SLOT_BITS-1:0];
        if (np != NONE_SLOT) begin
          we = 1'b1;
          waddr = np[SLOT_BITS-1:0];
          wdata.next = fs;
        end
      end
      S_LINKN: if (nn != NONE_SLOT) begin
        we = 1'b1;
        waddr = nn[SLOT_BITS-1:0];
        wdata.prev = fs;
      end
      S_FREE: begin
        raddr = nn[SLOT_BITS-1:0];
        if (np != NONE_SLOT) begin
          we = 1'b1;
          waddr = np[SLOT_BITS-1:0];
          wdata.next = nn;
        end
      end
      S_FRN: if (nn != NONE_SLOT) begin
        we = 1'b1;
        waddr = nn[SLOT_BITS-1:0];
        wdata.prev = np;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      arena <= OFFSET_BITS'(65536);
      valid <= '0;
      head <= NONE_SLOT;
      tail <= NONE_SLOT;
      total <= '0;
      used <= OFFSET_BITS'(PAGE_HEADER_BYTES);
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            arena <= cfg_data;
            valid <= '0;
            head <= NONE_SLOT;
            tail <= NONE_SLOT;
            total <= '0;
            used <= OFFSET_BITS'(PAGE_HEADER_BYTES);
          end else if (req_valid && !req_stall) begin
            rtype <= req_type;
            roff <= block_offset;
            rsize <= request_bytes;
            rtag <= owner_tag;
            idx <= '0;
            ret <= NONE_SLOT;
            unique case (req_type)
              REQ_ALLOC: begin
                fs <= free_idx;
                cur <= tail;
                steps <= '0;
                if (SUM_BITS'(used) + SUM_BITS'(request_bytes) > SUM_BITS'(arena)
                    || free_idx == NONE_SLOT) begin
                  rstat <= ST_NOMEM;
                  state <= S_DONE;
                end else if (head == NONE_SLOT) begin
                  if (PAGE_HDR + BLOCK_HDR + SUM_BITS'(request_bytes)
                      > SUM_BITS'(arena)) begin
                    rstat <= ST_NOMEM;
                    state <= S_DONE;
                  end else begin
                    new_start <= PAGE_HDR;
                    np <= NONE_SLOT;
                    nn <= NONE_SLOT;
                    state <= S_PLACE;
                  end
                end else begin
                  state <= S_ARD;
                end
              end
              REQ_FREE, REQ_NEXT, REQ_PREV: begin
                if (block_offset == '0) begin
                  if (req_type == REQ_FREE) begin
                    rstat <= ST_INVALID;
                    state <= S_DONE;
                  end else begin
                    cur <= (req_type == REQ_NEXT) ? head : tail;
                    state <= S_WALK;
                  end
                end else begin
                  state <= S_FIND;
                end
              end
              REQ_CLEAR: begin
                valid <= '0;
                head <= NONE_SLOT;
                tail <= NONE_SLOT;
                total <= '0;
                used <= OFFSET_BITS'(PAGE_HEADER_BYTES);
                rstat <= ST_OK;
                state <= S_DONE;
              end
              default: begin
                rstat <= ST_INVALID;
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FIND: begin
          cur <= LINK_BITS'(idx);
          state <= S_FCHK;
        end
        S_FCHK: begin
          if (valid[cur[SLOT_BITS-1:0]] &&
              t_start + BLOCK_HDR == SUM_BITS'(roff)) begin
            tcur <= rdata;
            np <= rdata.prev;
            nn <= rdata.next;
            if (rtype == REQ_FREE) begin
              ret <= cur;
              valid[cur[SLOT_BITS-1:0]] <= 1'b0;
              total <= total - 7'd1;
              used <= used - OFFSET_BITS'(BLOCK_HDR + SUM_BITS'(rdata.size));
              if (rdata.prev == NONE_SLOT) head <= rdata.next;
              if (rdata.next == NONE_SLOT) tail <= rdata.prev;
              rstat <= ST_OK;
              state <= S_FREE;
            end else begin
              cur <= (rtype == REQ_NEXT) ? rdata.next : rdata.prev;
              state <= S_WALK;
            end
          end else if (idx == (SLOT_BITS+1)'(MAX_BLOCKS - 1)) begin
            rstat <= ST_INVALID;
            state <= S_DONE;
          end else begin
            idx <= idx + 1'b1;
            state <= S_FIND;
          end
        end
        S_FREE: state <= S_FRN;
        S_FRN: begin
          cur <= ret;
          state <= S_WCHK;
        end
        S_WALK: begin
          if (cur == NONE_SLOT) begin
            rstat <= ST_END;
            state <= S_DONE;
          end else begin
            rstat <= ST_OK;
            ret <= cur;
            state <= S_WCHK;
          end
        end
        S_WCHK: state <= S_DONE; // registered read of ret slot ready next
        S_ARD: state <= S_ACHK;
        S_ACHK: begin
          if (steps == total) begin
            rstat <= ST_NOMEM;
            state <= S_DONE;
          end else if (rdata.next == NONE_SLOT &&
                       t_end + need <= SUM_BITS'(arena)) begin
            new_start <= t_end;
            np <= cur;
            nn <= NONE_SLOT;
            state <= S_PLACE;
          end else if (rdata.prev == NONE_SLOT && PAGE_HDR + need <= t_start) begin
            new_start <= PAGE_HDR;
            np <= NONE_SLOT;
            nn <= cur;
            state <= S_PLACE;
          end else if (rdata.next != NONE_SLOT) begin
            tcur <= rdata;
            state <= S_ANRD;
          end else begin
            steps <= steps + 7'd1;
            cur <= head;
            state <= S_ARD;
          end
        end
        S_ANRD: state <= S_ANCK;
        S_ANCK: begin
          if (SUM_BITS'(tcur.start) + BLOCK_HDR + SUM_BITS'(tcur.size) + need
              <= t_start) begin
            new_start <= SUM_BITS'(tcur.start) + BLOCK_HDR + SUM_BITS'(tcur.size);
            np <= cur;
            nn <= tcur.next;
            state <= S_PLACE;
          end else begin
            steps <= steps + 7'd1;
            cur <= tcur.next;
            state <= S_ARD;
          end
        end
        S_PLACE: begin
          valid[fs[SLOT_BITS-1:0]] <= 1'b1;
          total <= total + 7'd1;
          used <= used + OFFSET_BITS'(need);
          if (np == NONE_SLOT) head <= fs;
          if (nn == NONE_SLOT) tail <= fs;
          ret <= fs;
          rstat <= ST_OK;
          state <= S_LINKP;
        end
        S_LINKP: state <= S_LINKN;
        S_LINKN: begin
          cur <= ret;
          state <= S_WCHK;
        end
        S_DONE: begin
          rsp_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register: for freed slots use the captured record
  assign out_load = (state == S_DONE);
  always_ff @(posedge clk) begin
    if (out_load) begin
      status <= rstat;
      live_blocks <= total;
      used_bytes <= used;
      if (ret == NONE_SLOT || rstat != ST_OK) begin
        result_offset <= '0;
        result_bytes <= '0;
        result_tag <= '0;
      end else if (rtype == REQ_FREE) begin
        result_offset <= OFFSET_BITS'(SUM_BITS'(tcur.start) + BLOCK_HDR);
        result_bytes <= tcur.size;
        result_tag <= tcur.tag;
      end else begin
        result_offset <= OFFSET_BITS'(t_start + BLOCK_HDR);
        result_bytes <= rdata.size;
        result_tag <= rdata.tag;
      end
    end
  end
endmodule

// File: hdl/aba_checker.sv
// ----------------------------------------------------------------------------
// aba_checker: port-level checks
// Handshake and result consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module aba_checker import aba_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input logic [1:0] status,
  input logic [OFFSET_BITS-1:0] result_offset,
  input logic [6:0] live_blocks,
  input logic cfg_ready
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(result_offset))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while result pending");
  a_live: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> live_blocks <= 7'(MAX_BLOCKS))
    else $error("live count out of range");
  a_nomem: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != ST_OK |-> result_offset == '0)
    else $error("offset on failed request");
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !rsp_valid)
    else $error("config open while busy");
endmodule

bind arena_block_allocator aba_checker u_aba_checker (
  .clk(clk), .rst(rst), .req_stall(req_stall),
  .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
  .result_offset(result_offset), .live_blocks(live_blocks),
  .cfg_ready(cfg_ready)
);

// File: verif/tb_arena_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arena_block_allocator: self-checking bench for the arena block allocator
// Drives a directed table, then random allocate/free/walk/clear traffic over
// several arena sizes, with random request gaps and response stall bursts.
// Responses are compared field by field with the table row or a behavioral allocator.
// ----------------------------------------------------------------------------
module tb_arena_block_allocator;
  import aba_pkg::*;

  typedef struct packed {
    logic [1:0]             st;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] nb;
    logic [TAG_BITS-1:0]    tg;
    logic [6:0]             live;
    logic [OFFSET_BITS-1:0] used;
  } alloc_rsp_t;

  typedef struct {
    logic [2:0]             rq;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] nb;
    logic [TAG_BITS-1:0]    tg;
    bit                     typed;
    alloc_rsp_t             r;
  } dir_row_t;

  localparam int NONE = MAX_BLOCKS;
  localparam int STALL_LIMIT = 5000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  logic [2:0]             req_type = REQ_CLEAR;
  logic [OFFSET_BITS-1:0] block_offset = '0;
  logic [OFFSET_BITS-1:0] request_bytes = '0;
  logic [TAG_BITS-1:0]    owner_tag = '0;
  logic                   rsp_valid;
  logic                   rsp_stall = 1'b0;
  logic [1:0]             status;
  logic [OFFSET_BITS-1:0] result_offset;
  logic [OFFSET_BITS-1:0] result_bytes;
  logic [TAG_BITS-1:0]    result_tag;
  logic [6:0]             live_blocks;
  logic [OFFSET_BITS-1:0] used_bytes;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [OFFSET_BITS-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  arena_block_allocator i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
    .block_offset(block_offset), .request_bytes(request_bytes),
    .owner_tag(owner_tag),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status),
    .result_offset(result_offset), .result_bytes(result_bytes),
    .result_tag(result_tag), .live_blocks(live_blocks), .used_bytes(used_bytes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow allocator state
  longint unsigned  arena_sz;
  longint unsigned  blk_start [MAX_BLOCKS];
  longint unsigned  blk_size  [MAX_BLOCKS];
  logic [31:0]      blk_tag   [MAX_BLOCKS];
  bit               blk_live  [MAX_BLOCKS];
  int               blk_next  [MAX_BLOCKS];
  int               blk_prev  [MAX_BLOCKS];
  int               first_blk, last_blk, n_live;
  longint unsigned  in_use;

  alloc_rsp_t rsp_q[$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;

  function automatic void wipe_arena();
    foreach (blk_live[i]) blk_live[i] = 1'b0;
    first_blk = NONE;
    last_blk = NONE;
    n_live = 0;
    in_use = PAGE_HEADER_BYTES;
  endfunction

  function automatic void link_blk(int s, longint unsigned st, longint unsigned sz,
                                   logic [31:0] tg, int p, int n);
    blk_start[s] = st & ((64'd1 << OFFSET_BITS) - 1);
    blk_size[s] = sz;
    blk_tag[s] = tg;
    blk_live[s] = 1'b1;
    blk_prev[s] = p;
    blk_next[s] = n;
    if (p == NONE) first_blk = s; else blk_next[p] = s;
    if (n == NONE) last_blk = s; else blk_prev[n] = s;
    n_live++;
    in_use += BLOCK_HEADER_BYTES + sz;
  endfunction

  function automatic int place_blk(longint unsigned sz, logic [31:0] tg);
    int s, t, n;
    longint unsigned need, fin;
    need = BLOCK_HEADER_BYTES + sz;
    s = NONE;
    if (in_use + sz > arena_sz) return NONE;
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (!blk_live[i]) begin
        s = i;
        break;
      end
    if (s == NONE) return NONE;
    if (first_blk == NONE) begin
      if (PAGE_HEADER_BYTES + need > arena_sz) return NONE;
      link_blk(s, PAGE_HEADER_BYTES, sz, tg, NONE, NONE);
      return s;
    end
    t = last_blk;
    for (int k = 0; k < n_live && t < MAX_BLOCKS; k++) begin
      fin = blk_start[t] + BLOCK_HEADER_BYTES + blk_size[t];
      n = blk_next[t];
      if (n == NONE && fin + need <= arena_sz) begin
        link_blk(s, fin, sz, tg, t, NONE);
        return s;
      end
      if (blk_prev[t] == NONE && PAGE_HEADER_BYTES + need <= blk_start[t]) begin
        link_blk(s, PAGE_HEADER_BYTES, sz, tg, NONE, t);
        return s;
      end
      if (n != NONE && fin + need <= blk_start[n]) begin
        link_blk(s, fin, sz, tg, t, n);
        return s;
      end
      t = (n != NONE) ? n : first_blk;
    end
    return NONE;
  endfunction

  function automatic int lookup_blk(longint unsigned off);
    if (off == 0) return NONE;
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (blk_live[i] && blk_start[i] + BLOCK_HEADER_BYTES == off) return i;
    return NONE;
  endfunction

  function automatic alloc_rsp_t report(logic [1:0] st, int s);
    alloc_rsp_t r;
    r = '0;
    r.st = st;
    if (s < MAX_BLOCKS) begin
      r.off = OFFSET_BITS'(blk_start[s] + BLOCK_HEADER_BYTES);
      r.nb = OFFSET_BITS'(blk_size[s]);
      r.tg = blk_tag[s];
    end
    r.live = 7'(n_live);
    r.used = OFFSET_BITS'(in_use);
    return r;
  endfunction

  function automatic alloc_rsp_t apply_req(logic [2:0] rq, logic [OFFSET_BITS-1:0] off,
                                           logic [OFFSET_BITS-1:0] nb, logic [31:0] tg);
    int s, r;
    case (rq)
      REQ_ALLOC: begin
        s = place_blk(nb, tg);
        return (s == NONE) ? report(ST_NOMEM, NONE) : report(ST_OK, s);
      end
      REQ_FREE: begin
        s = lookup_blk(off);
        if (s == NONE) return report(ST_INVALID, NONE);
        if (blk_prev[s] == NONE) first_blk = blk_next[s];
        else blk_next[blk_prev[s]] = blk_next[s];
        if (blk_next[s] == NONE) last_blk = blk_prev[s];
        else blk_prev[blk_next[s]] = blk_prev[s];
        blk_live[s] = 1'b0;
        n_live--;
        in_use -= BLOCK_HEADER_BYTES + blk_size[s];
        return report(ST_OK, s);
      end
      REQ_NEXT, REQ_PREV: begin
        if (off == 0) begin
          r = (rq == REQ_NEXT) ? first_blk : last_blk;
        end else begin
          s = lookup_blk(off);
          if (s == NONE) return report(ST_INVALID, NONE);
          r = (rq == REQ_NEXT) ? blk_next[s] : blk_prev[s];
        end
        return (r >= MAX_BLOCKS) ? report(ST_END, NONE) : report(ST_OK, r);
      end
      REQ_CLEAR: begin
        wipe_arena();
        return report(ST_OK, NONE);
      end
      default: return report(ST_INVALID, NONE);
    endcase
  endfunction

  function automatic logic [OFFSET_BITS-1:0] live_offset();
    int b;
    b = $urandom_range(0, MAX_BLOCKS - 1);
    for (int i = 0; i < MAX_BLOCKS; i++)
      if (blk_live[(b + i) % MAX_BLOCKS])
        return OFFSET_BITS'(blk_start[(b + i) % MAX_BLOCKS] + BLOCK_HEADER_BYTES);
    return '0;
  endfunction

  task automatic send_req(logic [2:0] rq, logic [OFFSET_BITS-1:0] off,
                          logic [OFFSET_BITS-1:0] nb, logic [31:0] tg,
                          bit typed, alloc_rsp_t typed_rsp);
    alloc_rsp_t p;
    req_valid <= 1'b1;
    req_type <= rq;
    block_offset <= off;
    request_bytes <= nb;
    owner_tag <= tg;
    do @(posedge clk); while (req_stall);
    p = apply_req(rq, off, nb, tg);
    rsp_q.push_back(typed ? typed_rsp : p);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_arena(logic [OFFSET_BITS-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arena_sz = v;
    wipe_arena();
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(int cnt, int alloc_pct, int max_sz);
    logic [2:0] rq;
    logic [OFFSET_BITS-1:0] off, nb;
    int w;
    for (int i = 0; i < cnt; i++) begin
      w = $urandom_range(0, 99);
      off = '0;
      nb = OFFSET_BITS'($urandom_range(0, max_sz));
      if ($urandom_range(0, 19) == 0) nb = OFFSET_BITS'($urandom);
      if (w < alloc_pct) begin
        rq = REQ_ALLOC;
      end else if (w < alloc_pct + (100 - alloc_pct) / 2) begin
        rq = REQ_FREE;
        off = ($urandom_range(0, 9) == 0) ? OFFSET_BITS'($urandom) : live_offset();
      end else if (w < 94) begin
        rq = $urandom_range(0, 1) ? REQ_NEXT : REQ_PREV;
        case ($urandom_range(0, 5))
          0: off = '0;
          1: off = OFFSET_BITS'($urandom);
          default: off = live_offset();
        endcase
      end else if (w < 97) begin
        rq = REQ_CLEAR;
      end else begin
        rq = 3'($urandom_range(REQ_CLEAR + 1, 7));
        off = OFFSET_BITS'($urandom);
      end
      send_req(rq, off, nb, $urandom, 1'b0, '0);
    end
  endtask

  // response side: random stall bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    alloc_rsp_t got, want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = '{status, result_offset, result_bytes, result_tag, live_blocks, used_bytes};
      if (rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response transfer %p", got);
      end else begin
        want = rsp_q.pop_front();
        if (got.st !== want.st || got.off !== want.off || got.nb !== want.nb ||
            got.tg !== want.tg || got.live !== want.live || got.used !== want.used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_tab [$];
    arena_sz = 65536;
    wipe_arena();
    dir_tab = '{
      '{REQ_NEXT,  0,       0,       0,          1, '{ST_END, 0, 0, 0, 0, 48}},
      '{REQ_FREE,  0,       0,       0,          1, '{ST_INVALID, 0, 0, 0, 0, 48}},
      '{REQ_ALLOC, 0,       0,       '1,         1, '{ST_OK, 96, 0, '1, 1, 96}},
      '{REQ_ALLOC, 0,       100,     0,          1, '{ST_OK, 144, 100, 0, 2, 244}},
      '{REQ_ALLOC, 0,       '1,      32'h5a5a,   1, '{ST_NOMEM, 0, 0, 0, 2, 244}},
      '{REQ_NEXT,  0,       0,       0,          1, '{ST_OK, 96, 0, '1, 2, 244}},
      '{REQ_NEXT,  96,      0,       0,          1, '{ST_OK, 144, 100, 0, 2, 244}},
      '{REQ_NEXT,  144,     0,       0,          1, '{ST_END, 0, 0, 0, 2, 244}},
      '{REQ_PREV,  0,       0,       0,          1, '{ST_OK, 144, 100, 0, 2, 244}},
      '{REQ_PREV,  96,      0,       0,          1, '{ST_END, 0, 0, 0, 2, 244}},
      '{REQ_NEXT,  '1,      0,       0,          1, '{ST_INVALID, 0, 0, 0, 2, 244}},
      '{REQ_FREE,  '1,      0,       0,          1, '{ST_INVALID, 0, 0, 0, 2, 244}},
      '{REQ_FREE,  96,      0,       0,          1, '{ST_OK, 96, 0, '1, 1, 196}},
      '{REQ_ALLOC, 0,       0,       32'h1234,   0, '0},
      '{REQ_ALLOC, 0,       5000,    32'hdead,   0, '0},
      '{REQ_PREV,  0,       0,       0,          0, '0},
      '{3'd5,      '1,      '1,      '1,         0, '0},
      '{3'd6,      0,       0,       0,          0, '0},
      '{3'd7,      0,       0,       0,          0, '0},
      '{REQ_CLEAR, 0,       0,       0,          1, '{ST_OK, 0, 0, 0, 0, 48}}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i])
      send_req(dir_tab[i].rq, dir_tab[i].off, dir_tab[i].nb, dir_tab[i].tg,
               dir_tab[i].typed, dir_tab[i].r);
    random_phase(60, 55, 2000);
    set_arena(2000);
    random_phase(110, 55, 150);
    set_arena(20'hFFFFF);
    random_phase(120, 85, 64);
    set_arena(64);
    random_phase(30, 60, 20);
    set_arena(40);
    random_phase(20, 60, 20);
    set_arena(700);
    random_phase(100, 55, 80);
    set_arena(65536);
    drain();
    calm = 1'b1;
    random_phase(90, 60, 500);
    req_valid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && rsp_q.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule

// File: sim.f
hdl/aba_pkg.sv
hdl/aba_table.sv
hdl/arena_block_allocator.sv
hdl/aba_checker.sv
verif/tb_arena_block_allocator.sv
